// ===== hw/rtl/sorted_priority_queue_top_defines.svh =====
// ----------------------------------------------------------------------------
// sorted priority queue assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// same-cycle implication
`define SPQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted priority queue check failed");

// next-cycle implication
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted priority queue check failed");

`endif

// ===== hw/rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// types and codes shared by the sorted priority queue modules
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DEPTH   = 16;
   localparam int ELEM_W  = 32;
   localparam int PRIO_W  = 16;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   localparam logic [1:0] CMD_QUERY = 2'd0;
   localparam logic [1:0] CMD_ENQ   = 2'd1;
   localparam logic [1:0] CMD_DEQ   = 2'd2;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_EMPTY = 2'd1;
   localparam logic [1:0] ERR_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]        command;
      logic [ELEM_W-1:0] element;
      logic [PRIO_W-1:0] priority_req;
   } req_type;

   typedef struct packed {
      logic [ELEM_W-1:0]  front_element;
      logic [PRIO_W-1:0]  front_priority;
      logic [COUNT_W-1:0] count;
      logic               empty_res;
      logic               full_res;
      logic [1:0]         error;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [PRIO_W-1:0] prio;
      logic [ELEM_W-1:0] elem;
   } entry_type;

   typedef struct packed {
      logic              enq;
      logic              deq;
      logic [PRIO_W-1:0] prio;
      logic [ELEM_W-1:0] elem;
   } cell_ctrl_type;

endpackage

// ===== hw/rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: compares against the incoming priority and
// takes the new entry, its upstream neighbor or its downstream neighbor
// ----------------------------------------------------------------------------
module spq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  spq_pkg::entry_type    prev_entry,
   input  logic                  prev_gt,
   input  spq_pkg::entry_type    next_entry,
   output spq_pkg::entry_type    entry,
   output logic                  gt
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;
   logic               take_new;

   // stored entry is served after the incoming one
   assign gt       = entry_ff.valid && (entry_ff.prio > ctrl.prio);
   assign take_new = (!entry_ff.valid || gt) && prev_entry.valid && !prev_gt;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.enq) begin
         if (prev_gt) begin
            entry_in = prev_entry;
         end else if (take_new) begin
            entry_in.valid = 1'b1;
            entry_in.prio  = ctrl.prio;
            entry_in.elem  = ctrl.elem;
         end
      end else if (ctrl.deq) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff.prio <= entry_in.prio;
      entry_ff.elem <= entry_in.elem;
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
   end

   assign entry = entry_ff;

endmodule

// ===== hw/rtl/sorted_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// bounded priority queue held as a sorted chain of cells
// ----------------------------------------------------------------------------
// A command (query, enqueue, dequeue) is taken when start is high and busy is
// low; busy is high during reset and in the cycle after it. Every command
// gives one result in the next cycle, shown for a single cycle with rsp_valid
// and not held for the receiver. A new command may follow in every cycle: all
// cells compare the incoming priority in parallel and shift or load together,
// so the cell chain sets a rate of one command per clock. Lower priority
// values are served first, equal priorities in arrival order.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   output spq_pkg::rsp_type rsp_data
);

   localparam int CNT_W = spq_pkg::COUNT_W;

   spq_pkg::entry_type    cell_entry [spq_pkg::DEPTH];
   logic                  cell_gt    [spq_pkg::DEPTH];
   spq_pkg::cell_ctrl_type ctrl;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [1:0]       error_ff;
   logic [1:0]       error_in;
   logic             rsp_valid_ff;
   logic             busy_ff;
   logic             accept;
   logic             full;
   logic             empty;

   assign accept = start && !busy_ff;
   assign full   = (count_ff == CNT_W'(spq_pkg::DEPTH));
   assign empty  = (count_ff == '0);

   always_comb begin
      ctrl.enq = accept && (req_data.command == spq_pkg::CMD_ENQ) && !full;
      ctrl.deq = accept && (req_data.command == spq_pkg::CMD_DEQ) && !empty;
      ctrl.prio = req_data.priority_req;
      ctrl.elem = req_data.element;
   end

   always_comb begin
      count_in = count_ff;
      error_in = spq_pkg::ERR_NONE;
      if (ctrl.enq) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.deq) begin
         count_in = count_ff - 1'b1;
      end
      case (req_data.command)
         spq_pkg::CMD_ENQ: begin
            if (full) begin
               error_in = spq_pkg::ERR_FULL;
            end
         end
         spq_pkg::CMD_DEQ: begin
            if (empty) begin
               error_in = spq_pkg::ERR_EMPTY;
            end
         end
         default: begin
            error_in = spq_pkg::ERR_NONE;
         end
      endcase
   end

   genvar g;
   generate
      for (g = 0; g < spq_pkg::DEPTH; g++) begin : g_cell
         spq_pkg::entry_type prev_entry;
         spq_pkg::entry_type next_entry;
         logic               prev_gt;

         if (g == 0) begin : g_head
            // head sentinel: always valid, never behind the new entry
            assign prev_entry = '{valid: 1'b1, prio: '0, elem: '0};
            assign prev_gt    = 1'b0;
         end else begin : g_body
            assign prev_entry = cell_entry[g-1];
            assign prev_gt    = cell_gt[g-1];
         end

         if (g == spq_pkg::DEPTH - 1) begin : g_tail
            assign next_entry = '{valid: 1'b0, prio: '0, elem: '0};
         end else begin : g_link
            assign next_entry = cell_entry[g+1];
         end

         spq_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .prev_entry (prev_entry),
            .prev_gt    (prev_gt),
            .next_entry (next_entry),
            .entry      (cell_entry[g]),
            .gt         (cell_gt[g])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         error_ff     <= spq_pkg::ERR_NONE;
         rsp_valid_ff <= 1'b0;
         busy_ff      <= 1'b1;
      end else begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
            error_ff <= error_in;
         end
      end
   end

   always_comb begin
      rsp_data.front_element  = cell_entry[0].valid ? cell_entry[0].elem : '0;
      rsp_data.front_priority = cell_entry[0].valid ? cell_entry[0].prio : '0;
      rsp_data.count          = count_ff;
      rsp_data.empty_res      = empty;
      rsp_data.full_res       = full;
      rsp_data.error          = error_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign busy      = busy_ff;

endmodule

// ===== hw/rtl/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker
// port-level checks on the sorted priority queue, bound to the top level
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_top_defines.svh"

module spq_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input spq_pkg::rsp_type rsp_data
);

   // every accepted command gives one transfer on the next cycle
   `SPQ_ASSERT_NEXT(a_rsp_follows, clock, reset, start && !busy, rsp_valid)
   `SPQ_ASSERT_NEXT(a_no_spurious_rsp, clock, reset, !(start && !busy), !rsp_valid)
   `SPQ_ASSERT_NOW(a_empty_count, clock, reset, rsp_valid, rsp_data.empty_res == (rsp_data.count == '0))
   `SPQ_ASSERT_NOW(a_empty_front, clock, reset, rsp_valid && rsp_data.empty_res, (rsp_data.front_element == '0) && (rsp_data.front_priority == '0))
   `SPQ_ASSERT_NOW(a_full_error, clock, reset, rsp_valid && (rsp_data.error == spq_pkg::ERR_FULL), rsp_data.full_res)

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
